### hw/rtl/flptw_pkg.sv
// shared types, codes and helpers for the four-level page table walker
package flptw_pkg;

    localparam int PAGE_SHIFT  = 12;
    localparam int INDEX_BITS  = 9;
    localparam int ADDR_W      = 64;
    localparam int VADDR_W     = 48;
    localparam int LEVEL_W     = 2;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int ENTRY_SHIFT = 3;

    localparam logic [ADDR_W-1:0] FRAME_MASK     = 64'h000F_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] KTEXT_BASE     = 64'hFFFF_FFFF_8000_0000;
    localparam logic [ADDR_W-1:0] KPHYS_RESET    = 64'h0000_0000_04A0_0000;
    localparam logic [ADDR_W-1:0] DMAP_RESET     = 64'hFFFF_8880_0000_0000;
    localparam logic [ADDR_W-1:0] ROOT_RESET     = 64'h0;

    // input commands
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_DATA = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_FAIL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_VADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KPHYS_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DMAP_BASE  = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

    typedef enum logic [1:0] {
        KIND_READ = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] virtual_address;
        logic [ADDR_W-1:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] walk_level;
    } out_item_t;

    // table index for a level, 0 root .. 3 leaf
    function automatic logic [INDEX_BITS-1:0] table_index(
        input logic [VADDR_W-1:0] va,
        input logic [LEVEL_W-1:0] level
    );
        logic [INDEX_BITS-1:0] idx;
        case (level)
            2'd0:    idx = va[PAGE_SHIFT+3*INDEX_BITS +: INDEX_BITS];
            2'd1:    idx = va[PAGE_SHIFT+2*INDEX_BITS +: INDEX_BITS];
            2'd2:    idx = va[PAGE_SHIFT+INDEX_BITS +: INDEX_BITS];
            default: idx = va[PAGE_SHIFT +: INDEX_BITS];
        endcase
        return idx;
    endfunction

    // byte offset of an entry within its table
    function automatic logic [ADDR_W-1:0] entry_offset(input logic [INDEX_BITS-1:0] idx);
        return {{(ADDR_W-INDEX_BITS-ENTRY_SHIFT){1'b0}}, idx, {ENTRY_SHIFT{1'b0}}};
    endfunction

endpackage

### hw/rtl/flptw_cfg.sv
// configuration registers and registered physical root table base
module flptw_cfg
    import flptw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    output logic [ADDR_W-1:0]    root_base
);

    logic [ADDR_W-1:0] root_vaddr_reg;
    logic [ADDR_W-1:0] kphys_base_reg;
    logic [ADDR_W-1:0] dmap_base_reg;
    logic [ADDR_W-1:0] root_base_reg;
    logic [ADDR_W-1:0] root_base_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_vaddr_reg <= ROOT_RESET;
            kphys_base_reg <= KPHYS_RESET;
            dmap_base_reg  <= DMAP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROOT_VADDR: root_vaddr_reg <= cfg_wdata;
                REG_KPHYS_BASE: kphys_base_reg <= cfg_wdata;
                REG_DMAP_BASE:  dmap_base_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // kernel text map vs direct map translation of the root table address
    always_comb begin
        if (root_vaddr_reg >= KTEXT_BASE) begin
            root_base_next = (root_vaddr_reg - KTEXT_BASE) + kphys_base_reg;
        end else begin
            root_base_next = root_vaddr_reg - dmap_base_reg;
        end
    end

    always_ff @(posedge aclk) begin
        root_base_reg <= root_base_next;
    end

    assign root_base = root_base_reg;

endmodule

### hw/rtl/flptw_walk.sv
// walk state and result formation for one item
module flptw_walk
    import flptw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  in_item_t          item,
    input  logic [ADDR_W-1:0] root_base,
    output logic              emits,
    output out_item_t         result
);

    logic [VADDR_W-1:0] saved_vaddr_reg;
    logic [VADDR_W-1:0] saved_vaddr_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               busy_reg;
    logic               busy_next;
    logic [ADDR_W-1:0]  frame;
    logic [LEVEL_W-1:0] level_inc;

    assign frame     = item.read_data & FRAME_MASK;
    assign level_inc = level_reg + 2'd1;

    always_comb begin
        saved_vaddr_next   = saved_vaddr_reg;
        level_next         = level_reg;
        busy_next          = busy_reg;
        emits              = 1'b0;
        result.result_kind = KIND_READ;
        result.address     = '0;
        result.walk_level  = level_reg;
        if (item.command == CMD_TRANSLATE) begin
            saved_vaddr_next   = item.virtual_address[VADDR_W-1:0];
            level_next         = LEVEL_ROOT;
            busy_next          = 1'b1;
            emits              = 1'b1;
            result.result_kind = KIND_READ;
            result.address     = root_base + entry_offset(
                table_index(item.virtual_address[VADDR_W-1:0], LEVEL_ROOT));
            result.walk_level  = LEVEL_ROOT;
        end else if (busy_reg && item.command == CMD_READ_DATA) begin
            emits = 1'b1;
            if (level_reg == LEVEL_LEAF) begin
                busy_next          = 1'b0;
                result.result_kind = KIND_DONE;
                result.address     = frame |
                    {{(ADDR_W-PAGE_SHIFT){1'b0}}, saved_vaddr_reg[PAGE_SHIFT-1:0]};
                result.walk_level  = LEVEL_LEAF;
            end else begin
                level_next         = level_inc;
                result.result_kind = KIND_READ;
                result.address     = frame + entry_offset(
                    table_index(saved_vaddr_reg, level_inc));
                result.walk_level  = level_inc;
            end
        end else if (busy_reg && item.command == CMD_READ_FAIL) begin
            emits              = 1'b1;
            busy_next          = 1'b0;
            result.result_kind = KIND_FAIL;
            result.address     = '0;
            result.walk_level  = level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_vaddr_reg <= '0;
            level_reg       <= '0;
            busy_reg        <= 1'b0;
        end else if (step_en) begin
            saved_vaddr_reg <= saved_vaddr_next;
            level_reg       <= level_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

### hw/rtl/four_level_page_table_walker.sv
// top level of the four-level page table walker
//
// usage:
//   s_ channel carries commands: translate a virtual address, hand back a
//   table entry read from memory, or report that such a read failed
//   m_ channel carries results: a memory read request for the next entry,
//   the final physical address, or a failure (address 0)
//   cfg port writes the root table virtual address, kernel physical base and
//   direct map base; user must write only with no item in flight (unchecked)
// path: an accepted item sits in the input register and its result is then
//   captured in the output register
// throughput: one item per cycle while m_ready is high; walk state is updated
//   in the same cycle the item leaves the input register, so back-to-back
//   commands see each other's state; memory round trips set the real pace
// reset: aresetn low clears the walk to idle and loads the register defaults;
//   items that produce no result (response while idle, unused command code)
//   simply drain from the input register
// stall: while m_ready is low the output register holds its item, the input
//   register fills and s_ready drops only once both are occupied
module four_level_page_table_walker
    import flptw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata
);

    in_item_t          in_item_reg;
    logic              in_valid_reg;
    out_item_t         out_item_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] root_base;
    logic              emits;
    out_item_t         result;
    logic              out_free;
    logic              in_adv;

    // physical root table base, recomputed from the registers every cycle
    flptw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .root_base (root_base)
    );

    // walk state and the result for the item in the input register
    flptw_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (in_adv),
        .item      (in_item_reg),
        .root_base (root_base),
        .emits     (emits),
        .result    (result)
    );

    // output register frees up when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_ready;
    // item leaves the input register if it has a place to go or makes no result
    assign in_adv   = in_valid_reg && (!emits || out_free);
    assign s_ready  = !in_valid_reg || in_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_adv && emits) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && emits) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
